FILE: hdl/spbg_pkg.sv
// Package for the snake pair block generator: widths, codes and shared types.
package spbg_pkg;

  localparam int BLOCK_PAIRS = 64;
  localparam int CNT_W       = $clog2(BLOCK_PAIRS + 1);
  localparam int ROW_W       = 22;
  localparam int IDX_W       = 20;
  localparam int PC_W        = 13;
  localparam int PI_W        = 12;
  localparam int N_W         = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_COUNT = 2'd0,
    CFG_PROCESS_INDEX = 2'd1,
    CFG_ITEM_COUNT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_EMIT  = 3'b100
  } seq_state_e;

  // enumeration position
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] partner;
    logic             odd;
    logic             more;
  } pos_t;

  typedef struct packed {
    logic [PC_W-1:0] pc_eff;
    logic [PI_W-1:0] pidx;
    logic [N_W-1:0]  n;
    logic            reload;
  } cfg_t;

endpackage

FILE: hdl/spbg_cfg.sv
// Configuration registers with zero-count fixup and reload request.
module spbg_cfg import spbg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [PC_W-1:0] pc_q;
  logic [PI_W-1:0] pi_q;
  logic [N_W-1:0]  n_q;
  logic            reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PC_W'(1);
      pi_q     <= '0;
      n_q      <= '0;
      reload_q <= 1'b0;
    end else begin
      reload_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_PROCESS_COUNT: begin
            pc_q     <= cfg_data_i[PC_W-1:0];
            reload_q <= 1'b1;
          end
          CFG_PROCESS_INDEX: begin
            pi_q     <= cfg_data_i[PI_W-1:0];
            reload_q <= 1'b1;
          end
          CFG_ITEM_COUNT: begin
            n_q      <= cfg_data_i[N_W-1:0];
            reload_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg_o.pc_eff = (pc_q == '0) ? PC_W'(1) : pc_q;
    cfg_o.pidx   = pi_q;
    cfg_o.n      = n_q;
    cfg_o.reload = reload_q;
  end

endmodule

FILE: hdl/spbg_step.sv
// Shared step unit: advances the enumeration position by one step.
module spbg_step import spbg_pkg::*; (
  input  pos_t cur_i,
  input  cfg_t cfg_i,
  input  logic adv_i,
  output pos_t nxt_o,
  output logic has_pair_o
);

  logic [ROW_W-1:0] n_ext;
  logic [ROW_W-1:0] p2;
  logic [ROW_W-1:0] pc2;
  logic [ROW_W-1:0] delta;
  logic [ROW_W-1:0] nrow;
  logic             row_lt;
  logic             prt_lt;

  always_comb begin
    n_ext  = {{(ROW_W-N_W){1'b0}}, cfg_i.n};
    p2     = {{(ROW_W-PI_W-1){1'b0}}, cfg_i.pidx, 1'b0};
    pc2    = {{(ROW_W-PC_W-1){1'b0}}, cfg_i.pc_eff, 1'b0};
    delta  = cur_i.odd ? (p2 + ROW_W'(1)) : (pc2 - p2 - ROW_W'(1));
    nrow   = cur_i.row + delta;
    row_lt = cur_i.row < n_ext;
    prt_lt = cur_i.partner < n_ext;

    has_pair_o = cur_i.more && row_lt && prt_lt;

    nxt_o = cur_i;
    if (adv_i) begin
      nxt_o.partner = cur_i.partner + ROW_W'(1);
    end else if (cur_i.more) begin
      if (!row_lt) begin
        nxt_o.more = 1'b0;
      end else if (!prt_lt) begin
        nxt_o.row     = nrow;
        nxt_o.partner = nrow + ROW_W'(1);
        nxt_o.odd     = !cur_i.odd;
      end
    end
  end

endmodule

FILE: hdl/snake_pair_block_generator.sv
// Top level of the snake pair block generator: sequencer, position state, output register.
//
// Usage: each transaction on the input channel (in_valid_i / in_stall_o, field restart_i)
// requests one block of up to 64 index pairs. Pairs leave on the output channel
// (out_valid_o / out_stall_i), one transaction per pair, the final one of a block with
// block_last_o set; a request that finds nothing left returns a single result with
// pair_valid_o low. exhausted_o is the same on every result of one block.
// Timing: a request runs two passes of the one shared step unit, which moves the
// enumeration position by one pair or one row skip per cycle (an output stall can hold it in
// the replay pass). The first pass counts the block and finds exhausted_o, the second
// replays it into the output register; in_stall_o stays high from acceptance until the
// last result of the block is loaded into the output register.
// An output stall holds the replay pass at its next pair; the held result does not change.
// Reset: P=1, p=0, N=0, enumeration at the first owned row, output empty.
// A write to one of the three registers while idle reloads the enumeration at the first owned row.
module snake_pair_block_generator import spbg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      first_index_o,
  output logic [IDX_W-1:0]      second_index_o,
  output logic                  pair_valid_o,
  output logic                  block_last_o,
  output logic                  exhausted_o
);

  cfg_t       cfg;
  seq_state_e state_q, state_d;
  pos_t       work_q, work_d;
  pos_t       start_q, start_d;
  pos_t       end_q, end_d;
  pos_t       reload_pos;
  pos_t       nxt;
  logic       adv;
  logic       has_pair;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic       done_q, done_d;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [IDX_W-1:0] second_q, second_d;
  logic             pv_q, pv_d;
  logic             last_q, last_d;
  logic             exh_q, exh_d;
  logic             out_free;
  logic             in_acc;

  spbg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spbg_step u_step (
    .cur_i      (work_q),
    .cfg_i      (cfg),
    .adv_i      (adv),
    .nxt_o      (nxt),
    .has_pair_o (has_pair)
  );

  always_comb begin
    reload_pos.row     = {{(ROW_W-PI_W){1'b0}}, cfg.pidx};
    reload_pos.partner = {{(ROW_W-PI_W){1'b0}}, cfg.pidx} + ROW_W'(1);
    reload_pos.odd     = 1'b0;
    reload_pos.more    = {1'b0, cfg.pidx} < cfg.pc_eff;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    start_d     = start_q;
    end_d       = end_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    done_d      = done_q;
    adv         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    first_d     = first_q;
    second_d    = second_q;
    pv_d        = pv_q;
    last_d      = last_q;
    exh_d       = exh_q;

    case (state_q)
      ST_IDLE: begin
        if (cfg.reload) begin
          work_d = reload_pos;
        end
        if (in_acc) begin
          if (restart_i || cfg.reload) begin
            work_d = reload_pos;
          end
          start_d = work_d;
          cnt_d   = '0;
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!work_q.more || (has_pair && cnt_q == CNT_W'(BLOCK_PAIRS))) begin
          done_d  = !work_q.more;
          end_d   = work_q;
          work_d  = start_q;
          total_d = cnt_q;
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          adv    = has_pair;
          work_d = nxt;
          if (has_pair) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (total_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            first_d     = '0;
            second_d    = '0;
            pv_d        = 1'b0;
            last_d      = 1'b1;
            exh_d       = done_q;
            work_d      = end_q;
            state_d     = ST_IDLE;
          end
        end else if (has_pair) begin
          if (out_free) begin
            adv         = 1'b1;
            work_d      = nxt;
            out_valid_d = 1'b1;
            first_d     = work_q.row[IDX_W-1:0];
            second_d    = work_q.partner[IDX_W-1:0];
            pv_d        = 1'b1;
            last_d      = (cnt_q + CNT_W'(1)) == total_q;
            exh_d       = done_q;
            cnt_d       = cnt_q + CNT_W'(1);
            if ((cnt_q + CNT_W'(1)) == total_q) begin
              work_d  = end_q;
              state_d = ST_IDLE;
            end
          end
        end else begin
          work_d = nxt;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      work_q      <= '{row: '0, partner: ROW_W'(1), odd: 1'b0, more: 1'b1};
      start_q     <= '0;
      end_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      work_q      <= work_d;
      start_q     <= start_d;
      end_q       <= end_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    pv_q     <= pv_d;
    last_q   <= last_d;
    exh_q    <= exh_d;
  end

  assign out_valid_o    = out_valid_q;
  assign first_index_o  = first_q;
  assign second_index_o = second_q;
  assign pair_valid_o   = pv_q;
  assign block_last_o   = last_q;
  assign exhausted_o    = exh_q;

  a_accept_to_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_COUNT)
    else $error("accepted transaction did not start the count pass");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> block_last_o)
    else $error("empty result without block_last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_index_o) &&
      $stable(second_index_o) && $stable(pair_valid_o) && $stable(block_last_o) &&
      $stable(exhausted_o))
    else $error("stalled result changed");

  a_replay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q <= total_q)
    else $error("replay emitted more pairs than counted");

endmodule

FILE: verif/snake_pair_block_generator_test.sv
// Self-checking testbench for the snake pair block generator: directed table, then random phases.
module snake_pair_block_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spbg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_FROM   = 150;
  localparam int TAIL_CYCLES  = 150;

  typedef struct packed {
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
    logic             pair_valid;
    logic             last;
    logic             exhausted;
  } pair_result_t;

  typedef enum logic {STEP_WRITE, STEP_REQUEST} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  typed;
    pair_result_t          want;
  } directed_row_t;

  localparam pair_result_t EMPTY_DONE = '{20'd0, 20'd0, 1'b0, 1'b1, 1'b1};
  localparam pair_result_t ONLY_PAIR  = '{20'd0, 20'd1, 1'b1, 1'b1, 1'b1};
  localparam pair_result_t NO_TYPED   = '0;
  localparam int NUM_DIRECTED = 33;

  localparam directed_row_t DIRECTED_PLAN [NUM_DIRECTED] = '{
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, EMPTY_DONE},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'd2,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, ONLY_PAIR},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, EMPTY_DONE},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b1, 1'b1, ONLY_PAIR},
    '{STEP_WRITE,   CFG_PROCESS_COUNT, 21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'd5,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'd12,       1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, EMPTY_DONE},
    '{STEP_WRITE,   CFG_PROCESS_COUNT, 21'd4,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_PROCESS_INDEX, 21'd3,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'd20,       1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b1, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_UNUSED,        21'h1FFFFF,   1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_PROCESS_INDEX, 21'd4,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, EMPTY_DONE},
    '{STEP_WRITE,   CFG_PROCESS_COUNT, 21'd4096,     1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_PROCESS_INDEX, 21'd4095,     1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'h1FFFFF,   1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_PROCESS_COUNT, 21'h1FFFFF,   1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_PROCESS_INDEX, 21'd0,        1'b0, 1'b0, NO_TYPED},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'd1,        1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b1, EMPTY_DONE},
    '{STEP_WRITE,   CFG_ITEM_COUNT,    21'h100000,   1'b0, 1'b0, NO_TYPED},
    '{STEP_REQUEST, CFG_UNUSED,        21'd0,        1'b0, 1'b0, NO_TYPED}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  restart_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [IDX_W-1:0]      first_index_o;
  logic [IDX_W-1:0]      second_index_o;
  logic                  pair_valid_o;
  logic                  block_last_o;
  logic                  exhausted_o;

  snake_pair_block_generator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [PC_W-1:0]  model_pc;
  logic [PI_W-1:0]  model_pidx;
  logic [N_W-1:0]   model_n;
  logic [ROW_W-1:0] snake_row;
  logic [ROW_W-1:0] snake_partner;
  bit               snake_odd;
  bit               snake_more;

  pair_result_t pending_pairs[$];
  bit           typed_pending = 1'b0;
  pair_result_t typed_want    = '0;
  bit           idling_on     = 1'b1;
  int           error_count   = 0;
  int           quiet_cycles  = 0;
  int           stall_left    = 0;

  function automatic int unsigned eff_process_count();
    return (model_pc == '0) ? 1 : int'(model_pc);
  endfunction

  task automatic reload_position();
    snake_row     = ROW_W'(model_pidx);
    snake_partner = snake_row + 1'b1;
    snake_odd     = 1'b0;
    snake_more    = int'(model_pidx) < eff_process_count();
  endtask

  task automatic settle_position();
    int unsigned step;
    while (snake_more) begin
      if (snake_row >= ROW_W'(model_n)) begin
        snake_more = 1'b0;
      end else if (snake_partner < ROW_W'(model_n)) begin
        break;
      end else begin
        step = snake_odd ? (2 * int'(model_pidx) + 1)
                         : (2 * eff_process_count() - 2 * int'(model_pidx) - 1);
        snake_row     = snake_row + ROW_W'(step);
        snake_partner = snake_row + 1'b1;
        snake_odd     = !snake_odd;
      end
    end
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PROCESS_COUNT: model_pc   = data[PC_W-1:0];
      CFG_PROCESS_INDEX: model_pidx = data[PI_W-1:0];
      CFG_ITEM_COUNT:    model_n    = data[N_W-1:0];
      default:           return;
    endcase
    reload_position();
  endtask

  task automatic predict_pair_block(input bit restart);
    pair_result_t blk[$];
    pair_result_t entry;
    bit           done;
    if (restart) reload_position();
    settle_position();
    while (snake_more && blk.size() < BLOCK_PAIRS) begin
      entry = '{snake_row[IDX_W-1:0], snake_partner[IDX_W-1:0], 1'b1, 1'b0, 1'b0};
      blk   = {blk, entry};
      snake_partner = snake_partner + 1'b1;
      settle_position();
    end
    done = !snake_more;
    if (blk.size() == 0) begin
      entry = '{20'd0, 20'd0, 1'b0, 1'b1, done};
      blk   = {blk, entry};
    end
    foreach (blk[k]) blk[k].exhausted = done;
    blk[blk.size()-1].last = 1'b1;
    if (typed_pending) pending_pairs = {pending_pairs, typed_want};
    else pending_pairs = {pending_pairs, blk};
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    bit           in_acc;
    bit           out_acc;
    pair_result_t want;
    if (rst_ni) begin
      in_acc  = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      if (cfg_we_i) apply_config(cfg_index_i, cfg_data_i);
      if (in_acc) predict_pair_block(restart_i);
      if (out_acc) begin
        if (pending_pairs.size() == 0) begin
          flag_error($sformatf("unexpected result %0h/%0h", first_index_o, second_index_o));
        end else begin
          want = pending_pairs.pop_front();
          check_field("first_index", first_index_o, want.first_idx);
          check_field("second_index", second_index_o, want.second_idx);
          check_field("pair_valid", pair_valid_o, want.pair_valid);
          check_field("block_last", block_last_o, want.last);
          check_field("exhausted", exhausted_o, want.exhausted);
        end
      end
      if (in_acc || out_acc) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d expected results outstanding", pending_pairs.size());
        $display("snake_pair_block_generator_test: errors");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_data_i  = CFG_DATA_W'($urandom);
  endtask

  task automatic send_request(input bit restart, input bit typed, input pair_result_t want);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    typed_pending = typed;
    typed_want    = want;
    restart_i     = restart;
    in_valid_i    = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned          pc;
    int unsigned          pidx;
    int unsigned          n;
    int unsigned          pc_eff;
    int                   random_sent;
    int                   phase_items;
    logic [CFG_DATA_W-1:0] noise;

    model_pc   = 13'd1;
    model_pidx = '0;
    model_n    = '0;
    reload_position();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == STEP_WRITE)
        write_register(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
      else
        send_request(DIRECTED_PLAN[i].restart, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       pc = 0;
        1:       pc = 4096;
        2:       pc = 8191;
        3:       pc = $urandom_range(0, 8191);
        default: pc = $urandom_range(1, 8);
      endcase
      pc_eff = (pc == 0) ? 1 : pc;
      case ($urandom_range(0, 9))
        0:       pidx = $urandom_range(0, 4095);
        1:       pidx = (pc_eff > 4095) ? 4095 : pc_eff;
        default: pidx = $urandom_range(0, (pc_eff > 4096) ? 4095 : pc_eff - 1);
      endcase
      case ($urandom_range(0, 11))
        0:       n = 21'h1FFFFF;
        1:       n = $urandom_range(0, 21'h1FFFFF);
        2:       n = 21'h100000;
        3:       n = $urandom_range(61, 400);
        default: n = $urandom_range(0, 60);
      endcase
      noise = CFG_DATA_W'($urandom);
      if ($urandom_range(0, 4) != 0)
        write_register(CFG_PROCESS_COUNT,
                       {($urandom_range(0, 1) ? noise[CFG_DATA_W-1:PC_W] : '0), PC_W'(pc)});
      if ($urandom_range(0, 4) != 0)
        write_register(CFG_PROCESS_INDEX,
                       {($urandom_range(0, 1) ? noise[CFG_DATA_W-1:PI_W] : '0), PI_W'(pidx)});
      if ($urandom_range(0, 4) != 0)
        write_register(CFG_ITEM_COUNT, CFG_DATA_W'(n));
      if ($urandom_range(0, 5) == 0)
        write_register(CFG_UNUSED, CFG_DATA_W'($urandom));

      phase_items = $urandom_range(2, 10);
      repeat (phase_items) begin
        idling_on = (random_sent < QUIET_FROM);
        if (random_sent % 40 == 20) drain_results();
        send_request($urandom_range(0, 7) == 0, 1'b0, NO_TYPED);
        random_sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0)
      $display("snake_pair_block_generator_test: clean");
    else
      $display("snake_pair_block_generator_test: errors");
    $finish;
  end

endmodule
